/* src/srarq_pkg.sv */
package srarq_pkg;

	// sequence space and window
	localparam int MAX_SEQ_NUM = 7;
	localparam int SEQ_MOD     = MAX_SEQ_NUM + 1;
	localparam int SEQ_W       = $clog2(SEQ_MOD);
	localparam int NR_BUFS     = SEQ_MOD / 2;
	localparam int SLOT_W      = (NR_BUFS > 1) ? $clog2(NR_BUFS) : 1;
	localparam int OUTST_W     = $clog2(NR_BUFS + 1);

	// stream widths
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 2;

	typedef logic [SEQ_W-1:0]   seq_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [OUTST_W-1:0] outst_t;

	typedef enum logic [2:0] {
		CMD_FRAME = 3'd0,
		CMD_CKSUM = 3'd1,
		CMD_RTO   = 3'd2,
		CMD_ATO   = 3'd3,
		CMD_READY = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_NAK  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACT_TX     = 2'd0,
		ACT_DLV    = 2'd1,
		ACT_STOP   = 2'd2,
		ACT_STATUS = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD,
		S_RX_MARK,
		S_DLV,
		S_DLV_WEND,
		S_NAK_INC,
		S_NAK_WIN,
		S_ACK,
		S_STATUS
	} state_t;

	typedef struct packed {
		action_t    action;
		logic [1:0] tx_kind;
		seq_t       tx_seq;
		seq_t       tx_ack;
		slot_t      slot;
		logic       ack_timer_restart;
		logic       net_enable;
		logic       refused;
		logic       last;
	} res_t;

	// buffer slot of a sequence number (window size is a power of two)
	function automatic slot_t slot_of(input seq_t s);
		slot_of = SLOT_W'(s % NR_BUFS);
	endfunction

endpackage

/* src/selective_repeat_arq_controller_core.sv */
// selective-repeat sliding-window controller, sender and receiver side
//
// input channel s_*: one event per item, event code in s_tuser, frame
// fields in s_tdata. output channel m_*: the results of the event, in
// order (transmits, deliveries by slot, timer stops), always closed by a
// status item that carries m_tlast.
//
// one event at a time: s_tready is high only while the sequencer idles.
// every step of an event goes through one shared window-compare and
// modular-increment unit, one step per cycle while the output register
// has room. a frame arrival steps through receive mark and deliveries
// (data) or resend (nak), then ack release; the status item is loaded
// into the output register as the sequencer returns to idle.
// if m_tready is low the sequencer holds until the output register frees,
// a new event may be accepted while the last status still waits.
// reset (arst_n low) empties both windows, clears the output register and
// allows a nak again.
module selective_repeat_arq_controller_core
	import srarq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// rx_kind[1:0], rx_seq[4:2], rx_ack[7:5], expired_seq[10:8], zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command[2:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tx_kind[1:0], tx_seq[4:2], tx_ack[7:5], slot[9:8],
	// ack_timer_restart[10], net_enable[11], refused[12], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// action[1:0]
	output logic [OUT_USER_W-1:0] m_tuser,
	output logic                  m_tlast
);

	state_t state_q, state_nxt;

	// latched event
	logic [2:0] cmd_q;
	logic [1:0] kind_q;
	seq_t       seq_q, ack_q, exp_q, want_q;
	logic       refused_q, restart_q;

	// protocol state
	seq_t         tx_ack_base_q, tx_next_q, rx_exp_q, rx_wend_q;
	outst_t       tx_outst_q;
	logic [NR_BUFS-1:0] rx_arrived_q;
	logic         nak_allowed_q;

	// output register
	logic m_valid_q;
	res_t m_item_q;

	// shared unit
	seq_t alu_a, alu_b, alu_c, alu_inc;
	logic alu_in_win;

	logic emit;
	res_t emit_item;
	logic adv;
	logic win_open;
	logic nak_hit;
	logic mark_hit;
	logic dlv_hit;
	logic ack_hit;

	srarq_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.c      (alu_c),
		.in_win (alu_in_win),
		.inc_a  (alu_inc)
	);

	// output register has room this cycle
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign win_open = (tx_outst_q < outst_t'(NR_BUFS));

	// frame to transmit, ack field is expected sequence minus one
	function automatic res_t mk_tx(input kind_t k, input seq_t s, input seq_t exp_seq);
		res_t r;
		r         = '0;
		r.action  = ACT_TX;
		r.tx_kind = k;
		r.tx_seq  = s;
		r.tx_ack  = seq_t'(exp_seq + seq_t'(MAX_SEQ_NUM));
		r.slot    = (k == KIND_DATA) ? slot_of(s) : '0;
		return r;
	endfunction

	// decisions of the current step
	assign nak_hit  = (kind_q == KIND_DATA) && (seq_q != rx_exp_q) && nak_allowed_q;
	assign mark_hit = alu_in_win && !rx_arrived_q[slot_of(seq_q)];
	assign dlv_hit  = rx_arrived_q[slot_of(rx_exp_q)];
	assign ack_hit  = alu_in_win && (tx_outst_q != '0);

	// operand select and emitted item
	always_comb begin
		alu_a     = tx_ack_base_q;
		alu_b     = ack_q;
		alu_c     = tx_next_q;
		emit      = 1'b0;
		emit_item = '0;
		case (state_q)
			S_CMD: begin
				alu_a = tx_next_q;
				case (cmd_q)
					CMD_READY: begin
						if (win_open) begin
							emit      = 1'b1;
							emit_item = mk_tx(KIND_DATA, tx_next_q, rx_exp_q);
						end
					end
					CMD_CKSUM: begin
						if (nak_allowed_q) begin
							emit      = 1'b1;
							emit_item = mk_tx(KIND_NAK, '0, rx_exp_q);
						end
					end
					CMD_RTO: begin
						emit      = 1'b1;
						emit_item = mk_tx(KIND_DATA, exp_q, rx_exp_q);
					end
					CMD_ATO: begin
						emit      = 1'b1;
						emit_item = mk_tx(KIND_ACK, '0, rx_exp_q);
					end
					CMD_FRAME: begin
						if (nak_hit) begin
							emit      = 1'b1;
							emit_item = mk_tx(KIND_NAK, '0, rx_exp_q);
						end
					end
					default: ;
				endcase
			end
			S_RX_MARK: begin
				alu_a = rx_exp_q;
				alu_b = seq_q;
				alu_c = rx_wend_q;
			end
			S_DLV: begin
				alu_a = rx_exp_q;
				if (dlv_hit) begin
					emit           = 1'b1;
					emit_item.action = ACT_DLV;
					emit_item.slot   = slot_of(rx_exp_q);
				end
			end
			S_DLV_WEND: begin
				alu_a = rx_wend_q;
			end
			S_NAK_INC: begin
				alu_a = ack_q;
			end
			S_NAK_WIN: begin
				alu_b = want_q;
				if (alu_in_win) begin
					emit      = 1'b1;
					emit_item = mk_tx(KIND_DATA, want_q, rx_exp_q);
				end
			end
			S_ACK: begin
				if (ack_hit) begin
					emit             = 1'b1;
					emit_item.action = ACT_STOP;
					emit_item.slot   = slot_of(tx_ack_base_q);
				end
			end
			S_STATUS: begin
				emit                        = 1'b1;
				emit_item.action            = ACT_STATUS;
				emit_item.ack_timer_restart = restart_q;
				emit_item.net_enable        = win_open;
				emit_item.refused           = refused_q;
				emit_item.last              = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_CMD;
			end
			S_CMD: begin
				if (adv) begin
					if (cmd_q == CMD_FRAME) begin
						if (kind_q == KIND_DATA) state_nxt = S_RX_MARK;
						else if (kind_q == KIND_NAK) state_nxt = S_NAK_INC;
						else state_nxt = S_ACK;
					end else begin
						state_nxt = S_STATUS;
					end
				end
			end
			S_RX_MARK: begin
				if (adv) state_nxt = mark_hit ? S_DLV : S_ACK;
			end
			S_DLV: begin
				if (adv) state_nxt = dlv_hit ? S_DLV_WEND : S_ACK;
			end
			S_DLV_WEND: begin
				if (adv) state_nxt = S_DLV;
			end
			S_NAK_INC: begin
				if (adv) state_nxt = S_NAK_WIN;
			end
			S_NAK_WIN: begin
				if (adv) state_nxt = S_ACK;
			end
			S_ACK: begin
				if (adv && !ack_hit) state_nxt = S_STATUS;
			end
			S_STATUS: begin
				if (adv) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// latch event on accept
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= s_tuser[2:0];
			kind_q <= s_tdata[1:0];
			seq_q  <= seq_t'(s_tdata[4:2]);
			ack_q  <= seq_t'(s_tdata[7:5]);
			exp_q  <= seq_t'(s_tdata[10:8]);
		end
		if (state_q == S_NAK_INC && adv) want_q <= alu_inc;
	end

	// protocol state updates, one step per cycle while the output register has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_ack_base_q <= '0;
			tx_next_q     <= '0;
			rx_exp_q      <= '0;
			rx_wend_q     <= seq_t'(NR_BUFS % SEQ_MOD);
			tx_outst_q    <= '0;
			rx_arrived_q  <= '0;
			nak_allowed_q <= 1'b1;
			refused_q     <= 1'b0;
			restart_q     <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				refused_q <= 1'b0;
				restart_q <= 1'b0;
			end
			if (adv) begin
				// every transmitted frame restarts the ack timer
				if (emit && emit_item.action == ACT_TX) begin
					restart_q <= 1'b1;
					if (emit_item.tx_kind == KIND_NAK) nak_allowed_q <= 1'b0;
				end
				case (state_q)
					S_CMD: begin
						if (cmd_q == CMD_READY) begin
							if (win_open) begin
								tx_outst_q <= outst_t'(tx_outst_q + 1'b1);
								tx_next_q  <= alu_inc;
							end else begin
								refused_q <= 1'b1;
							end
						end
						// accepted data arrival restarts the ack timer
						if (cmd_q == CMD_FRAME && kind_q == KIND_DATA && !emit)
							restart_q <= 1'b1;
					end
					S_RX_MARK: begin
						if (mark_hit) rx_arrived_q[slot_of(seq_q)] <= 1'b1;
					end
					S_DLV: begin
						if (dlv_hit) begin
							rx_arrived_q[slot_of(rx_exp_q)] <= 1'b0;
							rx_exp_q      <= alu_inc;
							nak_allowed_q <= 1'b1;
							restart_q     <= 1'b1;
						end
					end
					S_DLV_WEND: begin
						rx_wend_q <= alu_inc;
					end
					S_ACK: begin
						if (ack_hit) begin
							tx_outst_q    <= outst_t'(tx_outst_q - 1'b1);
							tx_ack_base_q <= alu_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) m_item_q <= emit_item;
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_item_q.action;
	assign m_tlast  = m_item_q.last;
	assign m_tdata  = {3'b000, m_item_q.refused, m_item_q.net_enable,
		m_item_q.ack_timer_restart, m_item_q.slot, m_item_q.tx_ack,
		m_item_q.tx_seq, m_item_q.tx_kind};

endmodule

/* src/srarq_alu.sv */
module srarq_alu
	import srarq_pkg::*;
(
	input  seq_t a,
	input  seq_t b,
	input  seq_t c,
	output logic in_win,
	output seq_t inc_a
);

	// circular window test a <= b < c
	assign in_win = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));

	// modular increment
	assign inc_a = (a == seq_t'(MAX_SEQ_NUM)) ? '0 : seq_t'(a + 1'b1);

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import srarq_pkg::*;

	localparam int RANDOM_ITEMS = 128;
	localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [2:0] cmd;
		logic [1:0] kind;
		seq_t       seq;
		seq_t       ack;
		seq_t       expd;
	} arq_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;

	always #5 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	selective_repeat_arq_controller_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// window state as the controller should hold it
	seq_t snd_base = '0;
	seq_t snd_next = '0;
	seq_t rcv_expect = '0;
	seq_t rcv_end = seq_t'(NR_BUFS % SEQ_MOD);
	int   snd_outst = 0;
	bit   rcv_got [NR_BUFS] = '{default: 1'b0};
	bit   nak_ok = 1'b1;
	bit   restart_flag;

	arq_item_t pending_q [$];
	res_t      result_q [$];

	int mismatches = 0;
	int n_events = 0;
	int n_random = 0;
	int n_results = 0;
	int n_deliver = 0;
	int n_stop = 0;
	int n_refused = 0;

	function automatic seq_t seq_add(input seq_t a, input int b);
		return seq_t'((int'(a) + b + 4 * SEQ_MOD) % SEQ_MOD);
	endfunction

	// b lies in the circular range [a, c)
	function automatic bit seq_between(input seq_t a, input seq_t b, input seq_t c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

	task automatic push_frame(input logic [1:0] kind, input seq_t seq);
		res_t r;
		r = '0;
		r.action = ACT_TX;
		r.tx_kind = kind;
		r.tx_seq = seq;
		r.tx_ack = seq_add(rcv_expect, MAX_SEQ_NUM);
		r.slot = (kind == KIND_DATA) ? slot_t'(seq % NR_BUFS) : '0;
		if (kind == KIND_NAK)
			nak_ok = 1'b0;
		result_q.push_back(r);
		restart_flag = 1'b1;
	endtask

	task automatic predict_event(input arq_item_t it);
		res_t r;
		seq_t want;
		bit   refused;
		refused = 1'b0;
		restart_flag = 1'b0;
		case (it.cmd)
			CMD_READY: begin
				if (snd_outst < NR_BUFS) begin
					snd_outst++;
					push_frame(KIND_DATA, snd_next);
					snd_next = seq_add(snd_next, 1);
				end else begin
					refused = 1'b1;
				end
			end
			CMD_FRAME: begin
				if (it.kind == KIND_DATA) begin
					if (it.seq != rcv_expect && nak_ok)
						push_frame(KIND_NAK, '0);
					else
						restart_flag = 1'b1;
					if (seq_between(rcv_expect, it.seq, rcv_end) &&
							!rcv_got[it.seq % NR_BUFS]) begin
						rcv_got[it.seq % NR_BUFS] = 1'b1;
						// walk the in-order run that is now complete
						while (rcv_got[rcv_expect % NR_BUFS]) begin
							r = '0;
							r.action = ACT_DLV;
							r.slot = slot_t'(rcv_expect % NR_BUFS);
							result_q.push_back(r);
							nak_ok = 1'b1;
							rcv_got[rcv_expect % NR_BUFS] = 1'b0;
							rcv_expect = seq_add(rcv_expect, 1);
							rcv_end = seq_add(rcv_end, 1);
							restart_flag = 1'b1;
						end
					end
				end
				if (it.kind == KIND_NAK) begin
					want = seq_add(it.ack, 1);
					if (seq_between(snd_base, want, snd_next))
						push_frame(KIND_DATA, want);
				end
				// cumulative ack, any kind including the undefined one
				while (seq_between(snd_base, it.ack, snd_next) && snd_outst > 0) begin
					snd_outst--;
					r = '0;
					r.action = ACT_STOP;
					r.slot = slot_t'(snd_base % NR_BUFS);
					result_q.push_back(r);
					snd_base = seq_add(snd_base, 1);
				end
			end
			CMD_CKSUM: begin
				if (nak_ok)
					push_frame(KIND_NAK, '0);
			end
			CMD_RTO: push_frame(KIND_DATA, it.expd);
			CMD_ATO: push_frame(KIND_ACK, '0);
			default: ;
		endcase
		r = '0;
		r.action = ACT_STATUS;
		r.ack_timer_restart = restart_flag;
		r.net_enable = (snd_outst < NR_BUFS);
		r.refused = refused;
		r.last = 1'b1;
		result_q.push_back(r);
	endtask

	// sender: bursts of random length, random gaps between them
	arq_item_t cur;
	int        burst_left = 4;
	int        gap_left = 0;
	bit        hold;

	always @(posedge clk) begin
		if (arst_n) begin
			hold = s_tvalid && !s_tready;
			if (s_tvalid && s_tready) begin
				predict_event(cur);
				n_events++;
			end
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					cur = pending_q.pop_front();
					s_tdata <= {5'b0, cur.expd, cur.ack, cur.seq, cur.kind};
					s_tuser <= cur.cmd;
					s_tvalid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] seen);
		if (seen !== want) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t: %s expected %0h, got %0h", $time, fname, want, seen);
		end
	endtask

	// receiver: stall pattern steps through six phases in turn
	int   rx_cycle = 0;
	res_t got;
	res_t want_res;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			got = '0;
			got.action = action_t'(m_tuser);
			got.tx_kind = m_tdata[1:0];
			got.tx_seq = m_tdata[4:2];
			got.tx_ack = m_tdata[7:5];
			got.slot = m_tdata[9:8];
			got.ack_timer_restart = m_tdata[10];
			got.net_enable = m_tdata[11];
			got.refused = m_tdata[12];
			got.last = m_tlast;
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: unexpected result, action %0h data %0h", $time, m_tuser,
						m_tdata);
			end else begin
				want_res = result_q.pop_front();
				check_field("action", want_res.action, got.action);
				check_field("tx_kind", want_res.tx_kind, got.tx_kind);
				check_field("tx_seq", want_res.tx_seq, got.tx_seq);
				check_field("tx_ack", want_res.tx_ack, got.tx_ack);
				check_field("slot", want_res.slot, got.slot);
				check_field("ack_timer_restart", want_res.ack_timer_restart,
					got.ack_timer_restart);
				check_field("net_enable", want_res.net_enable, got.net_enable);
				check_field("refused", want_res.refused, got.refused);
				check_field("last", want_res.last, got.last);
				check_field("zero fill", '0, m_tdata[15:13]);
				if (want_res.action == ACT_DLV)
					n_deliver++;
				if (want_res.action == ACT_STOP)
					n_stop++;
				if (want_res.refused)
					n_refused++;
			end
		end
		rx_cycle++;
		case ((rx_cycle >> 6) % 6)
			0, 3:    m_tready <= 1'b1;
			1:       m_tready <= $urandom_range(0, 1);
			2:       m_tready <= (rx_cycle % 4 == 0);
			4:       m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= (rx_cycle % 8 < 5);
		endcase
	end

	// watchdog on handshake activity
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic add_item(input logic [2:0] cmd, input logic [1:0] kind, input seq_t seq,
			input seq_t ack, input seq_t expd);
		arq_item_t it;
		it.cmd = cmd;
		it.kind = kind;
		it.seq = seq;
		it.ack = ack;
		it.expd = expd;
		pending_q.push_back(it);
	endtask

	task automatic wait_drained(input bit for_results);
		do
			@(negedge clk);
		while (pending_q.size() != 0 || s_tvalid || (for_results && result_q.size() != 0));
	endtask

	// random rounds, shaped from the current window state
	task automatic random_round();
		int   scen;
		int   cnt;
		int   n;
		int   outst;
		int   tmp;
		int   j;
		int   offs [4];
		seq_t nxt;
		seq_t first;
		logic [2:0] cmd;
		scen = $urandom_range(0, 9);
		if (scen <= 3) begin
			// sender side: new frames, then an ack or a nak from the peer
			cnt = $urandom_range(1, 5);
			n = (cnt < NR_BUFS - snd_outst) ? cnt : NR_BUFS - snd_outst;
			nxt = seq_add(snd_next, n);
			outst = snd_outst + n;
			for (int i = 0; i < cnt; i++)
				add_item(CMD_READY, $urandom_range(0, 3), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 7));
			if ($urandom_range(0, 2) != 0)
				add_item(CMD_FRAME, ($urandom_range(0, 7) == 0) ? 2'd3 : KIND_ACK,
					$urandom_range(0, 7), seq_add(nxt, -1 - $urandom_range(0, outst)),
					$urandom_range(0, 7));
			else
				add_item(CMD_FRAME, KIND_NAK, $urandom_range(0, 7),
					seq_add(snd_base, $urandom_range(0, outst) - 1), $urandom_range(0, 7));
			n_random += cnt + 1;
		end else if (scen <= 6) begin
			// receiver side: a shuffled run of data frames inside the window
			offs = '{0, 1, 2, 3};
			for (int i = 0; i < 4; i++) begin
				j = $urandom_range(0, 3);
				tmp = offs[i];
				offs[i] = offs[j];
				offs[j] = tmp;
			end
			cnt = $urandom_range(1, 4);
			first = seq_add(rcv_expect, offs[0]);
			for (int i = 0; i < cnt; i++)
				add_item(CMD_FRAME, KIND_DATA, seq_add(rcv_expect, offs[i]),
					seq_add(snd_base, $urandom_range(0, snd_outst) - 1),
					$urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0) begin
				add_item(CMD_FRAME, KIND_DATA, first, $urandom_range(0, 7),
					$urandom_range(0, 7));
				cnt++;
			end
			n_random += cnt;
		end else if (scen == 7) begin
			// line errors and timers
			cnt = $urandom_range(1, 3);
			for (int i = 0; i < cnt; i++) begin
				case ($urandom_range(0, 2))
					0: add_item(CMD_CKSUM, $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom_range(0, 7), $urandom_range(0, 7));
					1: add_item(CMD_RTO, $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom_range(0, 7), ($urandom_range(0, 1) == 0) ?
						seq_add(snd_base, $urandom_range(0, 3)) : seq_t'($urandom_range(0, 7)));
					default: add_item(CMD_ATO, $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom_range(0, 7), $urandom_range(0, 7));
				endcase
			end
			n_random += cnt;
		end else if (scen == 8) begin
			// noise, unknown commands included
			cnt = $urandom_range(2, 4);
			for (int i = 0; i < cnt; i++) begin
				cmd = $urandom_range(0, 7);
				add_item(cmd, $urandom_range(0, 3), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 7));
				if (cmd <= CMD_READY)
					n_random++;
			end
		end else begin
			// broken traffic: frames beyond the receive window, undefined kind
			cnt = $urandom_range(1, 3);
			for (int i = 0; i < cnt; i++)
				add_item(CMD_FRAME, ($urandom_range(0, 1) == 0) ? KIND_DATA : 2'd3,
					seq_add(rcv_expect, $urandom_range(NR_BUFS, SEQ_MOD - 1)),
					$urandom_range(0, 7), $urandom_range(0, 7));
			n_random += cnt;
		end
	endtask

	initial begin
		bit paused;
		paused = 1'b0;
		// fill the send window, then one more ready is refused
		repeat (4)
			add_item(CMD_READY, KIND_DATA, 3'd0, 3'd0, 3'd0);
		add_item(CMD_READY, 2'd3, 3'd7, 3'd7, 3'd7);
		// checksum error sends a nak, a second one is held back
		add_item(CMD_CKSUM, KIND_DATA, 3'd0, 3'd0, 3'd0);
		add_item(CMD_CKSUM, KIND_NAK, 3'd7, 3'd7, 3'd7);
		// retransmit timeouts, one for a frame that is not outstanding
		add_item(CMD_RTO, KIND_DATA, 3'd0, 3'd0, 3'd2);
		add_item(CMD_RTO, KIND_ACK, 3'd0, 3'd0, 3'd7);
		add_item(CMD_ATO, KIND_DATA, 3'd0, 3'd0, 3'd0);
		// out of order data, then the gap filled and two slots delivered, twice, with a duplicate
		add_item(CMD_FRAME, KIND_DATA, 3'd1, 3'd7, 3'd0);
		add_item(CMD_FRAME, KIND_DATA, 3'd0, 3'd7, 3'd0);
		add_item(CMD_FRAME, KIND_DATA, 3'd3, 3'd7, 3'd0);
		add_item(CMD_FRAME, KIND_DATA, 3'd3, 3'd7, 3'd0);
		add_item(CMD_FRAME, KIND_DATA, 3'd2, 3'd7, 3'd0);
		// data beyond the receive window
		add_item(CMD_FRAME, KIND_DATA, 3'd1, 3'd7, 3'd0);
		// cumulative ack, nak resend, undefined kind as ack
		add_item(CMD_FRAME, KIND_ACK, 3'd0, 3'd1, 3'd0);
		add_item(CMD_FRAME, KIND_NAK, 3'd0, 3'd1, 3'd0);
		add_item(CMD_FRAME, 2'd3, 3'd7, 3'd3, 3'd7);
		// unknown commands only report status
		add_item(3'd5, 2'd3, 3'd7, 3'd7, 3'd7);
		add_item(3'd6, KIND_DATA, 3'd0, 3'd0, 3'd0);
		add_item(3'd7, KIND_NAK, 3'd5, 3'd2, 3'd5);
		// three more frames, then one cumulative ack releases them all
		repeat (3)
			add_item(CMD_READY, KIND_DATA, 3'd0, 3'd0, 3'd0);
		add_item(CMD_FRAME, KIND_ACK, 3'd7, 3'd6, 3'd7);
		wait_drained(1'b1);

		while (n_random < RANDOM_ITEMS) begin
			wait_drained(1'b0);
			if (!paused && n_random >= RANDOM_ITEMS / 2) begin
				// let the output side empty completely once
				wait_drained(1'b1);
				paused = 1'b1;
			end
			random_round();
		end

		wait_drained(1'b1);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d events (%0d random) and %0d results", n_events, n_random,
			n_results);
		$display("including %0d deliveries, %0d timer stops, %0d refused ready events",
			n_deliver, n_stop, n_refused);
		if (mismatches == 0 && result_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
src/srarq_pkg.sv
src/srarq_alu.sv
src/selective_repeat_arq_controller_core.sv
bench/testbench.sv
